// ===== src/svpa_pkg.sv =====
// ----------------------------------------------------------------------------
// svpa_pkg
// Types and constants for the three-voice sound precedence arbiter.
// ----------------------------------------------------------------------------
package svpa_pkg;

    localparam int VOICES_DEF = 3;
    localparam int VW         = 2;   // voice field width
    localparam int SW         = 8;   // sound number width
    localparam int PW         = 8;   // precedence width
    localparam int EW         = 10;  // element code width
    localparam int CW         = 12;  // coordinate width

    typedef enum logic [1:0] {
        OP_REQUEST  = 2'd0,
        OP_COMMIT   = 2'd1,
        OP_FINISHED = 2'd2,
        OP_OFF      = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CMD_STOP  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    // per-voice action decided during evaluation, or set to stop by all off
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_START = 2'd2,
        ACT_BOTH  = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic [1:0]    operation;
        logic [VW-1:0] voice;
        logic [SW-1:0] sound_id;
        logic [PW-1:0] request_precedence;
        logic          request_looped;
        logic          request_force;
        logic [EW-1:0] element_code;
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
    } t_in;

    typedef struct packed {
        logic          command;
        logic [VW-1:0] out_voice;
        logic [SW-1:0] out_sound;
        logic [EW-1:0] out_element;
        logic [CW-1:0] out_x;
        logic [CW-1:0] out_y;
        logic          last;
    } t_out;

    typedef struct packed {
        logic [SW-1:0] sound;
        logic [PW-1:0] prec;
        logic          looped;
        logic          force_rs;
        logic [EW-1:0] element;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } t_pend;

    typedef struct packed {
        logic [SW-1:0] sound;
        logic [PW-1:0] prec;
        logic          looped;
        logic [EW-1:0] element;
    } t_play;

endpackage

// ===== src/sound_voice_priority_arbiter.sv =====
// ----------------------------------------------------------------------------
// sound_voice_priority_arbiter
// Per-voice sound request arbitration by precedence, stop/start sequencing.
// ----------------------------------------------------------------------------
// Request and finished: busy stays low, no result.
// Commit: busy while the voices are evaluated in turn (shared compare), then
// while each voice is emitted in turn, a stop-then-start voice giving both
// results; a voice without a command leaves a gap in the results. All off:
// busy while three stops are emitted. No stalls; start is ignored while busy.
// Synchronous active-low reset clears all slots and the sequencer.
module sound_voice_priority_arbiter
    import svpa_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_req,
    output logic o_valid,
    output t_out o_res
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_state        r_state,  n_state;
    logic [IW-1:0] r_idx,    n_idx;
    logic          r_sub,    n_sub;
    logic          r_commit, n_commit;
    t_act          r_act  [VOICES];
    t_act          n_act  [VOICES];
    t_pend         r_pend [VOICES];
    t_pend         n_pend [VOICES];
    t_play         r_play [VOICES];
    t_play         n_play [VOICES];
    logic          r_valid,  n_valid;
    t_out          r_out,    n_out;

    logic          w_accept;
    logic          w_vok;
    logic [IW-1:0] w_sel;
    t_pend         w_q;
    t_play         w_p;
    logic          w_go;
    t_act          w_eval;
    logic          w_later;
    logic          w_final;
    logic [VW-1:0] w_vout;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_vok    = (i_req.voice != '0) && (32'(i_req.voice) <= VOICES);
    assign w_sel    = busy ? r_idx : IW'(i_req.voice - VW'(1));
    assign w_q      = r_pend[w_sel];
    assign w_p      = r_play[w_sel];
    assign w_vout   = VW'({1'b0, r_idx} + (IW+1)'(1));

    // shared start decision for the voice under evaluation (rule differs by voice)
    always_comb begin
        case (r_idx)
            IW'(0): begin
                w_go = (w_q.prec >= w_p.prec);
            end
            IW'(1): begin
                w_go = (w_p.sound == '0) || w_q.force_rs || (w_q.prec > w_p.prec);
            end
            default: begin
                w_go = !(!w_p.looped && w_q.looped && (w_p.sound != '0));
            end
        endcase
        if (w_q.sound != '0) begin
            w_eval = !w_go ? ACT_NONE : (w_q.looped ? ACT_START : ACT_BOTH);
        end else begin
            w_eval = w_p.looped ? ACT_STOP : ACT_NONE;
        end
    end

    always_comb begin
        w_later = 1'b0;
        for (int k = 0; k < VOICES; k++) begin
            if ((k > 32'(r_idx)) && (r_act[k] != ACT_NONE)) begin
                w_later = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_sub    = r_sub;
        n_commit = r_commit;
        n_act    = r_act;
        n_pend   = r_pend;
        n_play   = r_play;
        n_valid  = 1'b0;
        n_out    = r_out;
        w_final  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.operation)
                        OP_REQUEST: begin
                            if (w_vok && (i_req.sound_id != '0) &&
                                (i_req.request_precedence >= w_q.prec)) begin
                                n_pend[w_sel].sound    = i_req.sound_id;
                                n_pend[w_sel].prec     = i_req.request_precedence;
                                n_pend[w_sel].looped   = i_req.request_looped;
                                n_pend[w_sel].force_rs = i_req.request_force;
                                n_pend[w_sel].element  = i_req.element_code;
                                n_pend[w_sel].x        = i_req.pos_x;
                                n_pend[w_sel].y        = i_req.pos_y;
                            end
                        end
                        OP_FINISHED: begin
                            if (w_vok) begin
                                n_play[w_sel].sound  = '0;
                                n_play[w_sel].prec   = '0;
                                n_play[w_sel].looped = 1'b0;
                            end
                        end
                        OP_COMMIT: begin
                            n_state  = S_EVAL;
                            n_idx    = '0;
                            n_sub    = 1'b0;
                            n_commit = 1'b1;
                        end
                        default: begin
                            for (int k = 0; k < VOICES; k++) begin
                                n_act[k] = ACT_STOP;
                            end
                            n_state  = S_EMIT;
                            n_idx    = '0;
                            n_sub    = 1'b0;
                            n_commit = 1'b0;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                n_act[r_idx] = w_eval;
                if (32'(r_idx) == VOICES - 1) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_EMIT: begin
                if ((r_act[r_idx] == ACT_STOP) ||
                    ((r_act[r_idx] == ACT_BOTH) && !r_sub)) begin
                    n_valid               = 1'b1;
                    n_out.command         = CMD_STOP;
                    n_out.out_voice       = w_vout;
                    n_out.out_sound       = w_p.sound;
                    n_out.out_element     = w_p.element;
                    n_out.out_x           = '0;
                    n_out.out_y           = '0;
                    n_out.last            = (r_act[r_idx] == ACT_STOP) && !w_later;
                    n_play[r_idx].sound   = '0;
                    n_play[r_idx].prec    = '0;
                    n_play[r_idx].looped  = 1'b0;
                end else if (r_act[r_idx] != ACT_NONE) begin
                    n_valid               = 1'b1;
                    n_out.command         = CMD_START;
                    n_out.out_voice       = w_vout;
                    n_out.out_sound       = w_q.sound;
                    n_out.out_element     = w_q.element;
                    n_out.out_x           = w_q.x;
                    n_out.out_y           = w_q.y;
                    n_out.last            = !w_later;
                    n_play[r_idx].sound   = w_q.sound;
                    n_play[r_idx].prec    = w_q.prec;
                    n_play[r_idx].looped  = w_q.looped;
                    n_play[r_idx].element = w_q.element;
                end
                if ((r_act[r_idx] == ACT_BOTH) && !r_sub) begin
                    n_sub = 1'b1;
                end else begin
                    n_sub   = 1'b0;
                    w_final = (32'(r_idx) == VOICES - 1);
                    if (w_final) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                        if (r_commit) begin
                            for (int k = 0; k < VOICES; k++) begin
                                n_pend[k] = '0;
                            end
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_sub    <= 1'b0;
            r_commit <= 1'b0;
            r_valid  <= 1'b0;
            for (int k = 0; k < VOICES; k++) begin
                r_act[k]  <= ACT_NONE;
                r_pend[k] <= '0;
                r_play[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_sub    <= n_sub;
            r_commit <= n_commit;
            r_valid  <= n_valid;
            r_act    <= n_act;
            r_pend   <= n_pend;
            r_play   <= n_play;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule
